[src/dpbp_pkg.sv]
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Shared widths, register indexes, reset values and fixed-point helpers.
// ----------------------------------------------------------------------------
package dpbp_pkg;

    // Image dimension limit default.
    localparam int MAX_IMAGE_DIM_DEF = 4096;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration register indexes.
    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_INV_FX    = 3'd2;
    localparam logic [2:0] REG_INV_FY    = 3'd3;
    localparam logic [2:0] REG_MAX_DEPTH = 3'd4;
    localparam logic [2:0] REG_IMG_W     = 3'd5;
    localparam logic [2:0] REG_IMG_H     = 3'd6;

    // Configuration reset values.
    localparam logic [15:0] MAX_DEPTH_RST = 16'd3000;
    localparam logic [12:0] IMG_W_RST     = 13'd640;
    localparam logic [12:0] IMG_H_RST     = 13'd480;

    // Saturating counters.
    localparam int          CNT_W   = 25;
    localparam logic [24:0] CNT_MAX = 25'h1FF_FFFF;

    // Q24 product to 1/16 mm: round half away from zero on the magnitude,
    // then negate for the camera frame axis and saturate to 24 bits signed.
    function automatic logic [23:0] round_negate_sat(input logic [PROD_W-1:0] prod,
                                                     input logic              offset_neg);
        logic [PROD_W:0]   sum;
        logic [PROD_W-24:0] q;
        logic [23:0]       res;
        sum = {1'b0, prod} + (PROD_W+1)'(24'h800000);
        q   = sum[PROD_W:24];
        if (offset_neg)
        begin
            // Negative offset turns into a positive axis value.
            if (q > (PROD_W-23)'(24'h7FFFFF))
                res = 24'h7FFFFF;
            else
                res = q[23:0];
        end
        else
        begin
            if (q >= (PROD_W-23)'(24'h800000))
                res = 24'h800000;
            else
                res = 24'(-q[23:0]);
        end
        return res;
    endfunction

endpackage

[src/dpbp_mult.sv]
// ----------------------------------------------------------------------------
// Depth pixel back-projection shared multiplier
// One registered unsigned multiplier reused for every product of a pixel.
// ----------------------------------------------------------------------------
module dpbp_mult
    import dpbp_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [PROD_W-1:0]  prod
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = {{MUL_B_W{1'b0}}, op_a} * {{MUL_A_W{1'b0}}, op_b};

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[src/depth_pixel_backprojection_unit.sv]
// ----------------------------------------------------------------------------
// Depth pixel back-projection unit
// Turns depth pixels into colored camera-frame points and tests box coverage.
// ----------------------------------------------------------------------------
// Each input transfer carries one depth pixel of a box. The unit accepts a
// pixel in ST_IDLE and steps through ST_MX1, ST_MX2, ST_MY1, ST_MY2 and
// ST_FIN before it takes the next pixel. The pace is set by a
// single 32x24 multiplier that is used four times per pixel: offset times
// depth and then times the reciprocal focal length, once for each image
// axis. A pixel is kept when its depth lies in (0, max_depth_mm], it lies
// inside the image (clamped to MAX_IMAGE_DIM) and both reciprocal focal
// lengths are non-zero. Kept pixels come out with point_valid set, forward in
// 1/16 mm and leftward/upward as the negated, rounded and saturated lateral
// offsets. Rejected pixels come out with all point fields zero. The pixel
// marked with tlast closes a box: its result carries tlast and box_keep,
// which is set when at least ten percent of the box's pixels were kept. The
// finished result sits in an output register, so the next pixel is accepted
// while it waits. Configuration registers are written with cfg_wr_en and
// must only be changed while no pixel is in flight.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit
    import dpbp_pkg::*;
#(
    parameter int MAX_IMAGE_DIM = MAX_IMAGE_DIM_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data,

    // Pixel input.
    input  logic        s_tvalid,
    output logic        s_tready,
    // depth_raw[15:0], column[27:16], row_index[39:28], red_in[47:40],
    // green_in[55:48], blue_in[63:56]
    input  logic [63:0] s_tdata,
    // last_of_box
    input  logic        s_tlast,

    // Point output.
    output logic        m_tvalid,
    input  logic        m_tready,
    // forward[19:0], leftward[43:20], upward[67:44], red_out[75:68],
    // green_out[83:76], blue_out[91:84], zero fill [95:92]
    output logic [95:0] m_tdata,
    // point_valid[0], box_keep[1]
    output logic [1:0]  m_tuser,
    // box_end
    output logic        m_tlast
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MX1  = 3'd1;
    localparam logic [2:0] ST_MX2  = 3'd2;
    localparam logic [2:0] ST_MY1  = 3'd3;
    localparam logic [2:0] ST_MY2  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam logic [12:0] DIM_LIMIT = 13'(MAX_IMAGE_DIM);

    // Configuration registers.
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [23:0] inv_fx_reg;
    logic [23:0] inv_fy_reg;
    logic [15:0] max_depth_reg;
    logic [12:0] img_w_reg;
    logic [12:0] img_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            inv_fx_reg    <= '0;
            inv_fy_reg    <= '0;
            max_depth_reg <= MAX_DEPTH_RST;
            img_w_reg     <= IMG_W_RST;
            img_h_reg     <= IMG_H_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_CENTER_X:  center_x_reg  <= cfg_wr_data[15:0];
                REG_CENTER_Y:  center_y_reg  <= cfg_wr_data[15:0];
                REG_INV_FX:    inv_fx_reg    <= cfg_wr_data;
                REG_INV_FY:    inv_fy_reg    <= cfg_wr_data;
                REG_MAX_DEPTH: max_depth_reg <= cfg_wr_data[15:0];
                REG_IMG_W:     img_w_reg     <= cfg_wr_data[12:0];
                REG_IMG_H:     img_h_reg     <= cfg_wr_data[12:0];
                default:       ;
            endcase
        end
    end

    // Unpack the input transfer.
    logic [15:0] in_depth;
    logic [11:0] in_col;
    logic [11:0] in_row;
    assign in_depth = s_tdata[15:0];
    assign in_col   = s_tdata[27:16];
    assign in_row   = s_tdata[39:28];

    // Keep decision and pixel offsets, worked out at the accepting edge.
    logic [12:0] width_lim;
    logic [12:0] height_lim;
    logic        in_keep;
    logic [17:0] du_x;
    logic [17:0] du_y;
    logic [17:0] mag_x_full;
    logic [17:0] mag_y_full;

    assign width_lim  = (img_w_reg < DIM_LIMIT) ? img_w_reg : DIM_LIMIT;
    assign height_lim = (img_h_reg < DIM_LIMIT) ? img_h_reg : DIM_LIMIT;
    assign in_keep    = (inv_fx_reg != '0) && (inv_fy_reg != '0) &&
                        (in_depth != '0) && (in_depth <= max_depth_reg) &&
                        ({1'b0, in_col} < width_lim) && ({1'b0, in_row} < height_lim);

    // Offsets in 1/16 pixel; their magnitude never exceeds 16 bits.
    assign du_x       = {2'b00, in_col, 4'b0000} - {2'b00, center_x_reg};
    assign du_y       = {2'b00, in_row, 4'b0000} - {2'b00, center_y_reg};
    assign mag_x_full = du_x[17] ? 18'(-du_x) : du_x;
    assign mag_y_full = du_y[17] ? 18'(-du_y) : du_y;

    // Pixel holding registers.
    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [15:0] depth_reg;
    logic [15:0] mag_x_reg;
    logic [15:0] mag_y_reg;
    logic        neg_x_reg;
    logic        neg_y_reg;
    logic [23:0] color_reg;
    logic        keep_reg;
    logic        last_reg;
    logic [23:0] left_reg;

    logic        in_xfer;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            depth_reg <= in_depth;
            mag_x_reg <= mag_x_full[15:0];
            mag_y_reg <= mag_y_full[15:0];
            neg_x_reg <= du_x[17];
            neg_y_reg <= du_y[17];
            color_reg <= s_tdata[63:40];
            keep_reg  <= in_keep;
            last_reg  <= s_tlast;
        end
    end

    // Shared multiplier: first step is offset * depth, second step takes
    // that product times the reciprocal focal length.
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_en;
    logic [PROD_W-1:0]  prod;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (state_reg)
            ST_MX1:
            begin
                mul_a = MUL_A_W'(mag_x_reg);
                mul_b = MUL_B_W'(depth_reg);
            end
            ST_MX2:
            begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = inv_fx_reg;
            end
            ST_MY1:
            begin
                mul_a = MUL_A_W'(mag_y_reg);
                mul_b = MUL_B_W'(depth_reg);
            end
            ST_MY2:
            begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = inv_fy_reg;
            end
            default:
                mul_en = 1'b0;
        endcase
    end

    dpbp_mult u_mult (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // The horizontal result is finished while the vertical product starts.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MY1)
            left_reg <= round_negate_sat(prod, neg_x_reg);
    end

    // Output register and box counters.
    logic        out_free;
    logic        load_out;
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tlast_reg;
    logic [CNT_W-1:0] kept_reg;
    logic [CNT_W-1:0] pixel_reg;
    logic [CNT_W-1:0] kept_next;
    logic [CNT_W-1:0] pixel_next;
    logic [CNT_W+3:0] kept_x10;
    logic             box_keep;
    logic [23:0]      up_val;

    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == ST_FIN) && out_free;

    // Counts including the current pixel.
    assign pixel_next = (pixel_reg < CNT_MAX) ? pixel_reg + 1'b1 : pixel_reg;
    assign kept_next  = (keep_reg && (kept_reg < CNT_MAX)) ? kept_reg + 1'b1 : kept_reg;
    assign kept_x10   = (CNT_W+4)'({kept_next, 3'b000}) + (CNT_W+4)'({kept_next, 1'b0});
    assign box_keep   = last_reg && (kept_x10 >= (CNT_W+4)'(pixel_next));
    assign up_val     = round_negate_sat(prod, neg_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            kept_reg     <= '0;
            pixel_reg    <= '0;
        end
        else
        begin
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (load_out)
            begin
                // The box closes with this pixel: start the next box at zero.
                kept_reg  <= last_reg ? '0 : kept_next;
                pixel_reg <= last_reg ? '0 : pixel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (keep_reg)
                m_tdata_reg <= {4'b0000, color_reg, up_val, left_reg, depth_reg, 4'b0000};
            else
                m_tdata_reg <= '0;
            m_tuser_reg <= {box_keep, keep_reg};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MX1;
            ST_MX1:  state_next = ST_MX2;
            ST_MX2:  state_next = ST_MY1;
            ST_MY1:  state_next = ST_MY2;
            ST_MY2:  state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
